// ===== sv/rfw_pkg.sv =====
`default_nettype none
package rfw_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WEIGHT_W  = FRAC_BITS + 1;

  localparam logic [63:0] ONE_Q60     = 64'h1000_0000_0000_0000;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921_FB54_442D_1846;

  localparam logic [2:0] KERN_GAUSS   = 3'd0;
  localparam logic [2:0] KERN_LINEAR  = 3'd1;
  localparam logic [2:0] KERN_CONST   = 3'd2;
  localparam logic [2:0] KERN_COSINE  = 3'd3;
  localparam logic [2:0] KERN_QUARTIC = 3'd4;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic [31:0]        filter_radius;
  } in_t;

  typedef struct packed {
    logic [32:0]         point_distance;
    logic [WEIGHT_W-1:0] filter_weight;
  } out_t;

  // classified pair: absolute deltas and a radius that is never zero
  typedef struct packed {
    logic [32:0] dx;
    logic [32:0] dy;
    logic [32:0] dz;
    logic [31:0] r;
  } pair_t;

  // round half up from Q60 to FRAC_BITS fraction bits
  function automatic logic [WEIGHT_W-1:0] to_weight(input logic [63:0] x);
    logic [63:0] t;
    t = x + (64'd1 << (59 - FRAC_BITS));
    return t[60:60-FRAC_BITS];
  endfunction

endpackage
`default_nettype wire

// ===== sv/rfw_mul.sv =====
`default_nettype none
// 64x64 product from four 32x32 partial products, one per cycle
module rfw_mul (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         go,
  input  wire logic [63:0]  a,
  input  wire logic [63:0]  b,
  output logic              done,
  output logic [127:0]      prod
);
  logic [63:0] ra, rb;
  logic [1:0]  cnt;
  logic        busy;
  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic [127:0] pp_sh;

  always_comb begin
    pa = cnt[1] ? ra[63:32] : ra[31:0];
    pb = cnt[0] ? rb[63:32] : rb[31:0];
    pp = pa * pb;
    pp_sh = {64'd0, pp} << ({6'd0, cnt[1]} * 7'd32 + {6'd0, cnt[0]} * 7'd32);
  end

  always_ff @(posedge clk) begin
    done <= !rst && !go && busy && (cnt == 2'd3);
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      ra   <= a;
      rb   <= b;
      prod <= '0;
      cnt  <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      prod <= prod + pp_sh;
      cnt  <= cnt + 2'd1;
      if (cnt == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/rfw_div.sv =====
`default_nettype none
// restoring divider, one quotient bit per cycle
module rfw_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [63:0]      quot
);
  logic [31:0] rem, dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] t, t_sub;

  always_comb begin
    t     = {rem, quot[63]};
    t_sub = t - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    done <= !rst && !go && busy && (cnt == 6'd63);
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      quot <= dividend;
      dvs  <= divisor;
      rem  <= '0;
      cnt  <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      if (t >= {1'b0, dvs}) begin
        rem  <= t_sub[31:0];
        quot <= {quot[62:0], 1'b1};
      end else begin
        rem  <= t[31:0];
        quot <= {quot[62:0], 1'b0};
      end
      cnt <= cnt + 6'd1;
      if (cnt == 6'd63) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/rfw_front.sv =====
`default_nettype none
// takes point pairs, forms absolute deltas, and queues them for the back end
module rfw_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rfw_pkg::in_t  in_data,
  output logic               q_valid,
  output rfw_pkg::pair_t     q_data,
  input  wire logic          q_pop
);
  rfw_pkg::pair_t mem [2];
  rfw_pkg::pair_t entry;
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push;

  function automatic logic [32:0] abs_diff(input logic signed [31:0] x,
                                           input logic signed [31:0] y);
    logic signed [33:0] d;
    d = {{2{x[31]}}, x} - {{2{y[31]}}, y};
    if (d < 0) d = -d;
    return d[32:0];
  endfunction

  always_comb begin
    entry.dx = abs_diff(in_data.first_x, in_data.second_x);
    entry.dy = abs_diff(in_data.first_y, in_data.second_y);
    entry.dz = abs_diff(in_data.first_z, in_data.second_z);
    entry.r  = (in_data.filter_radius == 32'd0) ? 32'd1 : in_data.filter_radius;
    in_ready = (count != 2'd2);
    push     = in_valid && in_ready;
    q_valid  = (count != 2'd0);
    q_data   = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= entry;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

// ===== sv/rfw_back.sv =====
`default_nettype none
// sequencer: squares, square root, then the kernel on the shared mul and div units
module rfw_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [2:0]     kern,
  input  wire logic           q_valid,
  input  wire rfw_pkg::pair_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rfw_pkg::out_t       out_data
);
  typedef enum logic [2:0] {ST_IDLE, ST_WAIT, ST_SQRT, ST_KSEL, ST_DONE} state_t;
  typedef enum logic [3:0] {
    OP_SQ, OP_TQ, OP_QQ, OP_TM, OP_TD, OP_SQE, OP_PHI, OP_PHI2, OP_CC, OP_U1, OP_U2
  } op_t;

  state_t state;
  op_t    op;

  logic [32:0] dy, dz;
  logic [31:0] r;
  logic [65:0] acc;
  logic [67:0] rad;
  logic [36:0] rem;
  logic [33:0] root;
  logic [1:0]  idx;
  logic [5:0]  cnt;
  logic [4:0]  k;
  logic [63:0] sum, val;
  logic [rfw_pkg::WEIGHT_W-1:0] w;

  logic         mul_go, mul_done, div_go, div_done;
  logic [63:0]  mul_a, mul_b, div_n, quot;
  logic [31:0]  div_d;
  logic [127:0] prod;

  logic [63:0] p60, p32, sum_next, cval, qs28;
  logic [65:0] acc_next;
  logic [38:0] rem_t;
  logic [36:0] trial;
  logic [31:0] dc;
  logic [5:0]  kk;
  logic [11:0] dk;
  logic        gauss, last;

  rfw_mul u_mul (
    .clk(clk), .rst(rst), .go(mul_go), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(prod)
  );

  rfw_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(div_n), .divisor(div_d),
    .done(div_done), .quot(quot)
  );

  always_comb begin
    p60      = prod[123:60];
    p32      = prod[95:32];
    qs28     = quot << 28;
    acc_next = acc + prod[65:0];
    rem_t    = {rem[36:0], rad[67:66]};
    trial    = {1'b0, root, 2'b01};
    dc       = (root < {2'b00, r}) ? root[31:0] : r;
    kk       = {k, 1'b0};
    dk       = {6'd0, kk} * ({6'd0, kk} - 12'd1);
    gauss    = (kern == rfw_pkg::KERN_GAUSS);
    last     = gauss ? (k == 5'd20) : (k == 5'd12);
    if (gauss) begin
      if (k[0]) sum_next = (quot > sum) ? 64'd0 : sum - quot;
      else      sum_next = sum + quot;
    end else begin
      if (k[0]) sum_next = sum - quot;
      else      sum_next = sum + quot;
    end
    if (sum_next[63])                  cval = 64'd0;
    else if (sum_next > rfw_pkg::ONE_Q60) cval = rfw_pkg::ONE_Q60;
    else                               cval = sum_next;
    q_pop = (state == ST_IDLE) && q_valid;
  end

  always_ff @(posedge clk) begin
    logic mul_go_next, div_go_next;
    mul_go_next = 1'b0;
    div_go_next = 1'b0;
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && (state != ST_DONE)) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            dy     <= q_data.dy;
            dz     <= q_data.dz;
            r      <= q_data.r;
            acc    <= '0;
            idx    <= '0;
            mul_a  <= {31'd0, q_data.dx};
            mul_b  <= {31'd0, q_data.dx};
            mul_go_next = 1'b1;
            op     <= OP_SQ;
            state  <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (mul_done || div_done) begin
            case (op)
              OP_SQ: begin
                acc <= acc_next;
                if (idx == 2'd2) begin
                  rad   <= {2'b00, acc_next};
                  rem   <= '0;
                  root  <= '0;
                  cnt   <= '0;
                  state <= ST_SQRT;
                end else begin
                  idx    <= idx + 2'd1;
                  mul_a  <= {31'd0, (idx == 2'd0) ? dy : dz};
                  mul_b  <= {31'd0, (idx == 2'd0) ? dy : dz};
                  mul_go_next = 1'b1;
                end
              end
              OP_TQ: begin
                case (kern)
                  rfw_pkg::KERN_GAUSS: begin
                    mul_a <= qs28; mul_b <= qs28; mul_go_next = 1'b1; op <= OP_QQ;
                  end
                  rfw_pkg::KERN_COSINE: begin
                    mul_a <= rfw_pkg::HALF_PI_Q60; mul_b <= quot;
                    mul_go_next = 1'b1; op <= OP_PHI;
                  end
                  rfw_pkg::KERN_QUARTIC: begin
                    mul_a <= qs28; mul_b <= qs28; mul_go_next = 1'b1; op <= OP_U1;
                  end
                  default: begin
                    w     <= rfw_pkg::to_weight(qs28);
                    state <= ST_DONE;
                  end
                endcase
              end
              OP_QQ, OP_PHI2: begin
                // series operand: 9 t^2 for the exponential, phi^2 for the cosine
                val    <= (op == OP_QQ) ? ((p60 << 3) + p60) : p60;
                sum    <= rfw_pkg::ONE_Q60;
                k      <= 5'd1;
                mul_a  <= rfw_pkg::ONE_Q60;
                mul_b  <= (op == OP_QQ) ? ((p60 << 3) + p60) : p60;
                mul_go_next = 1'b1;
                op     <= OP_TM;
              end
              OP_TM: begin
                div_n  <= p60;
                div_d  <= gauss ? {27'd0, k} : {20'd0, dk};
                div_go_next = 1'b1;
                op     <= OP_TD;
              end
              OP_TD: begin
                sum  <= sum_next;
                if (last) begin
                  cnt    <= '0;
                  mul_a  <= gauss ? sum_next : cval;
                  mul_b  <= gauss ? sum_next : cval;
                  mul_go_next = 1'b1;
                  op     <= gauss ? OP_SQE : OP_CC;
                end else begin
                  k      <= k + 5'd1;
                  mul_a  <= quot;
                  mul_b  <= val;
                  mul_go_next = 1'b1;
                  op     <= OP_TM;
                end
              end
              OP_SQE: begin
                if (cnt == 6'd6) begin
                  w     <= rfw_pkg::to_weight(p60);
                  state <= ST_DONE;
                end else begin
                  cnt    <= cnt + 6'd1;
                  mul_a  <= p60;
                  mul_b  <= p60;
                  mul_go_next = 1'b1;
                end
              end
              OP_PHI: begin
                mul_a <= p32; mul_b <= p32; mul_go_next = 1'b1; op <= OP_PHI2;
              end
              OP_U1: begin
                mul_a <= p60; mul_b <= p60; mul_go_next = 1'b1; op <= OP_U2;
              end
              default: begin
                w     <= rfw_pkg::to_weight(p60);
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_SQRT: begin
          if (rem_t >= {2'b00, trial}) begin
            rem  <= 37'(rem_t - {2'b00, trial});
            root <= {root[32:0], 1'b1};
          end else begin
            rem  <= rem_t[36:0];
            root <= {root[32:0], 1'b0};
          end
          rad <= rad << 2;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd33) state <= ST_KSEL;
        end
        ST_KSEL: begin
          case (kern)
            rfw_pkg::KERN_GAUSS: begin
              if (root >= {r, 2'b00}) begin
                // at or beyond four radii: weight is zero
                w     <= '0;
                state <= ST_DONE;
              end else begin
                div_n <= {2'b00, root, 28'd0};
                div_d <= r; div_go_next = 1'b1; op <= OP_TQ; state <= ST_WAIT;
              end
            end
            rfw_pkg::KERN_LINEAR, rfw_pkg::KERN_QUARTIC: begin
              div_n <= {r - dc, 32'd0};
              div_d <= r; div_go_next = 1'b1; op <= OP_TQ; state <= ST_WAIT;
            end
            rfw_pkg::KERN_COSINE: begin
              div_n <= {dc, 32'd0};
              div_d <= r; div_go_next = 1'b1; op <= OP_TQ; state <= ST_WAIT;
            end
            rfw_pkg::KERN_CONST: begin
              w     <= rfw_pkg::WEIGHT_W'(1 << rfw_pkg::FRAC_BITS);
              state <= ST_DONE;
            end
            default: begin
              w     <= '0;
              state <= ST_DONE;
            end
          endcase
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid               <= 1'b1;
            out_data.point_distance <= root[32:0];
            out_data.filter_weight  <= w;
            state                   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
    mul_go <= mul_go_next;
    div_go <= div_go_next;
  end
endmodule
`default_nettype wire

// ===== sv/radial_filter_weight_unit.sv =====
// The back-end sequencer finishes one item before it takes the next; it shares
// one 64x64 multiplier and one divider, and the queue holds two items.
// Reset (synchronous, active high) empties the queue and output, kernel_type -> 0.
`default_nettype none
module radial_filter_weight_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rfw_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rfw_pkg::out_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_data
);
  logic           kern_type;
  logic [2:0]     kernel_type;
  logic           q_valid, q_pop;
  rfw_pkg::pair_t q_data;

  assign cfg_ready = 1'b1;
  assign kern_type = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) kernel_type <= rfw_pkg::KERN_GAUSS;
    else if (kern_type) kernel_type <= cfg_data;
  end

  rfw_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  rfw_back u_back (
    .clk(clk), .rst(rst), .kern(kernel_type), .q_valid(q_valid),
    .q_data(q_data), .q_pop(q_pop), .out_valid(out_valid),
    .out_ready(out_ready), .out_data(out_data)
  );
endmodule
`default_nettype wire

// ===== tb/tb_radial_filter_weight_unit.sv =====
`default_nettype none
module tb_radial_filter_weight_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rfw_pkg::*;

  localparam longint CYCLE_LIMIT = 4000000;
  localparam int     HOLD_CYCLES = 400;
  localparam int     TAIL_CYCLES = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_data = '0;

  radial_filter_weight_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  out_t       pending_weights[$];
  logic [2:0] kernel_shadow = KERN_GAUSS;
  int         errors = 0;
  longint     cycles = 0;
  bit         tx_idle_on = 1'b1;
  bit         rx_idle_on = 1'b1;
  int         hold_req = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         rx_gap = 0;

  // ---------------- predictor ----------------
  function automatic logic [63:0] mul_sh(input logic [63:0] a, input logic [63:0] b,
                                         input int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> sh);
  endfunction

  function automatic logic [63:0] delta_abs(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
    longint x, y;
    x = a;
    y = b;
    return (x >= y) ? 64'(x - y) : 64'(y - x);
  endfunction

  function automatic logic [WEIGHT_W-1:0] round_q60(input logic [63:0] x);
    logic [63:0] t;
    t = (x + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
    return t[WEIGHT_W-1:0];
  endfunction

  function automatic logic [63:0] exp_neg(input logic [63:0] s);
    logic [63:0] sum, term;
    sum = ONE_Q60;
    term = ONE_Q60;
    for (int k = 1; k <= 20; k++) begin
      term = mul_sh(term, s, 60) / 64'(k);
      if (k % 2 == 1) sum = (term > sum) ? 64'd0 : sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [63:0] cosine_q60(input logic [63:0] phi);
    logic [63:0] phi2, term;
    longint sum;
    phi2 = mul_sh(phi, phi, 60);
    term = ONE_Q60;
    sum = longint'(ONE_Q60);
    for (int k = 1; k <= 12; k++) begin
      term = mul_sh(term, phi2, 60) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) return 64'd0;
    if (64'(sum) > ONE_Q60) return ONE_Q60;
    return 64'(sum);
  endfunction

  function automatic out_t predict_weight(input in_t p, input logic [2:0] kern);
    logic [63:0]  dx, dy, dz, r, d, c, dc, u, q, e, tq, phi;
    logic [127:0] ss;
    out_t         res;
    dx = delta_abs(p.first_x, p.second_x);
    dy = delta_abs(p.first_y, p.second_y);
    dz = delta_abs(p.first_z, p.second_z);
    ss = {64'd0, dx} * {64'd0, dx} + {64'd0, dy} * {64'd0, dy} + {64'd0, dz} * {64'd0, dz};
    d = 0;
    for (int b = 33; b >= 0; b--) begin
      c = d | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= ss) d = c;
    end
    r = {32'd0, p.filter_radius};
    if (r == 0) r = 1;
    dc = (d < r) ? d : r;
    res.point_distance = d[32:0];
    res.filter_weight = '0;
    case (kern)
      KERN_GAUSS: begin
        if (d < 4 * r) begin
          q = ((d << 28) / r) << 28;
          e = exp_neg(9 * mul_sh(q, q, 60));
          for (int i = 0; i < 7; i++) e = mul_sh(e, e, 60);
          res.filter_weight = round_q60(e);
        end
      end
      KERN_LINEAR: begin
        u = (((r - dc) << 32) / r) << 28;
        res.filter_weight = round_q60(u);
      end
      KERN_CONST: res.filter_weight = WEIGHT_W'(1 << FRAC_BITS);
      KERN_COSINE: begin
        tq = (dc << 32) / r;
        phi = mul_sh(HALF_PI_Q60, tq, 32);
        e = cosine_q60(phi);
        res.filter_weight = round_q60(mul_sh(e, e, 60));
      end
      KERN_QUARTIC: begin
        u = (((r - dc) << 32) / r) << 28;
        u = mul_sh(u, u, 60);
        u = mul_sh(u, u, 60);
        res.filter_weight = round_q60(u);
      end
      default: res.filter_weight = '0;
    endcase
    return res;
  endfunction

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_weights.size() == 0) begin
        $display("%0t: unexpected result dist=%h weight=%h", $time,
                 out_data.point_distance, out_data.filter_weight);
        errors++;
      end else begin
        out_t want;
        want = pending_weights.pop_front();
        if (out_data.point_distance !== want.point_distance) begin
          $display("%0t: point_distance expected %h actual %h", $time,
                   want.point_distance, out_data.point_distance);
          errors++;
        end
        if (out_data.filter_weight !== want.filter_weight) begin
          $display("%0t: filter_weight expected %h actual %h", $time,
                   want.filter_weight, out_data.filter_weight);
          errors++;
        end
      end
    end
  end

  // ---------------- receiver ----------------
  always @(posedge clk) begin
    int gap;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ready <= 1'b0;
    end else if (out_ready && out_valid) begin
      gap = rx_idle_on ? $urandom_range(0, 15) : 0;
      if (gap == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        rx_gap <= gap - 1;
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_radial_filter_weight_unit failed");
      $finish;
    end
  end

  // ---------------- sender and helpers ----------------
  task automatic send_pair(input in_t p);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
    pending_weights.push_back(predict_weight(p, kernel_shadow));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_weights.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_kernel(input logic [2:0] k);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data <= k;
    do @(posedge clk); while (!cfg_ready);
    kernel_shadow = k;
    cfg_valid <= 1'b0;
  endtask

  function automatic in_t make_pair(input logic [31:0] fx, input logic [31:0] fy,
                                    input logic [31:0] fz, input logic [31:0] sx,
                                    input logic [31:0] sy, input logic [31:0] sz,
                                    input logic [31:0] r);
    in_t p;
    p.first_x = fx; p.first_y = fy; p.first_z = fz;
    p.second_x = sx; p.second_y = sy; p.second_z = sz;
    p.filter_radius = r;
    return p;
  endfunction

  // mostly points within a few radii of each other; some fully random noise
  function automatic in_t rand_pair();
    in_t    p;
    longint span, off;
    logic [31:0] r;
    p = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(0, 9) < 7) begin
      r = ($urandom_range(1, 1 << 16)) << $urandom_range(0, 14);
      if ($urandom_range(0, 30) == 0) r = 0;
      p.filter_radius = r;
      span = (r == 0) ? 4 : longint'(r) * 3;
      if (span > (longint'(1) << 30)) span = longint'(1) << 30;
      off = longint'($urandom_range(0, 32'(span))) * 2 - span;
      p.second_x = 32'(longint'(p.first_x) + off / 2);
      off = longint'($urandom_range(0, 32'(span))) * 2 - span;
      p.second_y = 32'(longint'(p.first_y) + off / 2);
      off = longint'($urandom_range(0, 32'(span))) * 2 - span;
      p.second_z = 32'(longint'(p.first_z) + off / 2);
    end
    return p;
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    logic [31:0] one, mx, mn;
    one = 32'h0001_0000;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    for (int k = KERN_GAUSS; k <= KERN_QUARTIC; k++) begin
      set_kernel(3'(k));
      send_pair(make_pair(0, 0, 0, 0, 0, 0, one));               // coincident points
      send_pair(make_pair(mx, mx, mx, mn, mn, mn, 32'hFFFF_FFFF)); // widest distance
      send_pair(make_pair(0, 0, 0, one, 0, 0, 0));               // zero radius
      send_pair(make_pair(0, 0, 0, 3 * one, 0, 0, 3 * one));     // distance equals radius
      send_pair(make_pair(one, 0, 0, -3 * one, 0, 0, one));      // four radii away
    end
  endtask

  task automatic test_random(input logic [2:0] k, input int count);
    set_kernel(k);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      send_pair(rand_pair());
    end
  endtask

  task automatic test_backpressure();
    set_kernel(KERN_CONST);
    tx_idle_on = 1'b0;
    hold_req <= hold_req + 1;
    for (int i = 0; i < 12; i++) send_pair(rand_pair());
    tx_idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    set_kernel(KERN_LINEAR);
    for (int i = 0; i < 6; i++) send_pair(rand_pair());
    wait_drain();
    for (int i = 0; i < 6; i++) send_pair(rand_pair());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_drain_pause();
    test_random(KERN_LINEAR, 250);
    test_random(KERN_CONST, 120);
    test_random(KERN_COSINE, 230);
    test_random(KERN_QUARTIC, 230);
    test_random(KERN_GAUSS, 150);
    test_random(3'd5, 40);
    test_random(3'd6, 40);
    test_random(3'd7, 40);
    test_random(KERN_LINEAR, 20);
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_weights.size() == 0) begin
      $display("tb_radial_filter_weight_unit passed");
    end else begin
      $display("tb_radial_filter_weight_unit failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== radial_filter_weight_unit.f =====
sv/rfw_pkg.sv
sv/rfw_mul.sv
sv/rfw_div.sv
sv/rfw_front.sv
sv/rfw_back.sv
sv/radial_filter_weight_unit.sv
tb/tb_radial_filter_weight_unit.sv
